### hdl/i2cm_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// i2cm_pkg
// Shared types and constants of the I2C master bit engine.
// ----------------------------------------------------------------------------
package i2cm_pkg;

    typedef enum logic [2:0] {
        CMD_IDLE  = 3'd0,
        CMD_START = 3'd1,
        CMD_STOP  = 3'd2,
        CMD_SEND  = 3'd3,
        CMD_RECV  = 3'd4,
        CMD_ACK   = 3'd5,
        CMD_NACK  = 3'd6
    } cmd_t;

    typedef enum logic [1:0] {
        KIND_NONE = 2'd0,
        KIND_TICK = 2'd1,
        KIND_CMD  = 2'd2
    } kind_t;

    localparam logic [2:0] MODE_TICK    = 3'd0;
    localparam logic [2:0] MODE_INVALID = 3'd7;

    localparam logic [0:0] CFG_ACK_TIMEOUT    = 1'b0;
    localparam logic [0:0] CFG_TICKS_PER_UNIT = 1'b1;

    localparam logic [15:0] ACK_TIMEOUT_RST    = 16'd1000;
    localparam logic [7:0]  TICKS_PER_UNIT_RST = 8'd1;

    localparam logic [3:0] PH_WAIT       = 4'd5;
    localparam logic [3:0] BITS_PER_BYTE = 4'd8;

    localparam int QUEUE_DEPTH = 2;
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    typedef struct packed {
        kind_t      kind;
        cmd_t       cmd;
        logic [7:0] tx_byte;
        logic       sda_line;
    } item_t;

    typedef struct packed {
        logic [QCNT_W-1:0] count;
        logic              full;
    } q_status_t;

    typedef struct packed {
        logic       scl_out;
        logic       sda_out;
        logic       busy_res;
        logic       done_res;
        logic       ack_received;
        logic [7:0] rx_byte;
    } result_t;

endpackage
`default_nettype wire

### hdl/i2cm_front.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// i2cm_front
// Unpacks an input transfer and classifies it as tick, command or no-op.
// ----------------------------------------------------------------------------
module i2cm_front (
    input  wire logic [2:0]     mode,
    input  wire logic [15:0]    data,
    output i2cm_pkg::item_t     item
);
    import i2cm_pkg::*;

    always_comb
    begin
        item.tx_byte  = data[7:0];
        item.sda_line = data[8];
        item.cmd      = CMD_IDLE;
        if (mode == MODE_TICK)
        begin
            item.kind = KIND_TICK;
        end
        else if (mode == MODE_INVALID)
        begin
            item.kind = KIND_NONE;
        end
        else
        begin
            item.kind = KIND_CMD;
            item.cmd  = cmd_t'(mode);
        end
    end

endmodule
`default_nettype wire

### hdl/i2cm_queue.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// i2cm_queue
// Two-entry FIFO between the classifier and the bit engine.
// ----------------------------------------------------------------------------
module i2cm_queue (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             push,
    input  i2cm_pkg::item_t       push_item,
    input  wire logic             pop,
    output logic                  head_valid,
    output i2cm_pkg::item_t       head_item,
    output i2cm_pkg::q_status_t   status
);
    import i2cm_pkg::*;

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;

    item_t             mem_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0] count_reg, count_next;
    logic              do_push, do_pop;

    assign status.count = count_reg;
    assign status.full  = (count_reg == QCNT_W'(QUEUE_DEPTH));
    assign head_valid   = (count_reg != '0);
    assign head_item    = mem_reg[rd_ptr_reg];
    assign do_push      = push && !status.full;
    assign do_pop       = pop && head_valid;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule
`default_nettype wire

### hdl/i2cm_back.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// i2cm_back
// Bit engine: phase sequencer, delay and ACK timers, configuration registers
// and the registered result stage.
// ----------------------------------------------------------------------------
module i2cm_back (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           in_valid,
    input  i2cm_pkg::item_t     in_item,
    output logic                pop,
    input  wire logic           cfg_we,
    input  wire logic [0:0]     cfg_index,
    input  wire logic [15:0]    cfg_data,
    output logic                out_valid,
    input  wire logic           out_ready,
    output i2cm_pkg::result_t   out_res
);
    import i2cm_pkg::*;

    logic [15:0] ack_timeout_reg;
    logic [7:0]  tpu_reg;

    cmd_t        cmd_reg, cmd_next;
    logic [3:0]  phase_reg, phase_next;
    logic [3:0]  bit_reg, bit_next;
    logic [7:0]  shift_reg, shift_next;
    logic [10:0] delay_reg, delay_next;
    logic [16:0] wait_reg, wait_next;
    logic        scl_reg, scl_next;
    logic        sda_reg, sda_next;
    logic        ack_reg, ack_next;
    logic [7:0]  rx_reg, rx_next;
    logic        done;
    logic        do_go;
    logic        ph_ok;
    logic [10:0] dly_dec;
    logic [3:0]  bit_inc;
    logic [7:0]  shift_in;

    logic [10:0] t_unit, hold1, hold2, hold5;
    logic        out_valid_reg;
    result_t     out_res_reg;

    assign t_unit = (tpu_reg == 8'd0) ? 11'd1 : {3'd0, tpu_reg};
    assign hold1  = t_unit;
    assign hold2  = {t_unit[9:0], 1'b0};
    assign hold5  = {t_unit[8:0], 2'b00} + t_unit;

    assign pop       = in_valid && (!out_valid_reg || out_ready);
    assign out_valid = out_valid_reg;
    assign out_res   = out_res_reg;

    always_comb
    begin
        cmd_next   = cmd_reg;
        phase_next = phase_reg;
        bit_next   = bit_reg;
        shift_next = shift_reg;
        delay_next = delay_reg;
        wait_next  = wait_reg;
        scl_next   = scl_reg;
        sda_next   = sda_reg;
        ack_next   = ack_reg;
        rx_next    = rx_reg;
        done       = 1'b0;
        do_go      = 1'b0;
        ph_ok      = 1'b0;
        dly_dec    = (delay_reg != 11'd0) ? delay_reg - 11'd1 : 11'd0;
        bit_inc    = bit_reg + 4'd1;
        shift_in   = {shift_reg[6:0], in_item.sda_line};

        if (in_item.kind == KIND_TICK && cmd_reg != CMD_IDLE)
        begin
            if (cmd_reg == CMD_SEND && phase_reg == PH_WAIT)
            begin
                if (!in_item.sda_line)
                begin
                    ack_next   = 1'b1;
                    phase_next = 4'd6;
                    do_go      = 1'b1;
                end
                else if (wait_reg > {1'b0, ack_timeout_reg})
                begin
                    ack_next   = 1'b0;
                    cmd_next   = CMD_STOP;
                    phase_next = 4'd0;
                    do_go      = 1'b1;
                end
                else
                begin
                    wait_next = wait_reg + 17'd1;
                end
            end
            else
            begin
                delay_next = dly_dec;
                if (dly_dec == 11'd0)
                begin
                    do_go = 1'b1;
                    if (cmd_reg == CMD_SEND && phase_reg == 4'd2)
                    begin
                        shift_next = {shift_reg[6:0], 1'b0};
                        bit_next   = bit_inc;
                        phase_next = (bit_inc < BITS_PER_BYTE) ? 4'd0 : 4'd3;
                    end
                    else if (cmd_reg == CMD_RECV && phase_reg == 4'd1)
                    begin
                        shift_next = shift_in;
                        bit_next   = bit_inc;
                        if (bit_inc < BITS_PER_BYTE)
                        begin
                            phase_next = 4'd0;
                        end
                        else
                        begin
                            rx_next    = shift_in;
                            phase_next = 4'd2;
                        end
                    end
                    else
                    begin
                        phase_next = phase_reg + 4'd1;
                    end
                end
            end
        end
        else if (in_item.kind == KIND_CMD && cmd_reg == CMD_IDLE)
        begin
            cmd_next   = in_item.cmd;
            phase_next = 4'd0;
            bit_next   = 4'd0;
            wait_next  = 17'd0;
            shift_next = (in_item.cmd == CMD_SEND) ? in_item.tx_byte : 8'd0;
            do_go      = 1'b1;
        end

        if (do_go)
        begin
            ph_ok = 1'b1;
            unique case (cmd_next)
                CMD_START:
                begin
                    unique case (phase_next)
                        4'd0:    begin sda_next = 1'b1; delay_next = hold1; end
                        4'd1:    begin scl_next = 1'b1; delay_next = hold5; end
                        4'd2:    begin sda_next = 1'b0; delay_next = hold5; end
                        4'd3:    begin scl_next = 1'b0; delay_next = hold2; end
                        default: ph_ok = 1'b0;
                    endcase
                end
                CMD_STOP:
                begin
                    unique case (phase_next)
                        4'd0:    begin scl_next = 1'b0; delay_next = hold2; end
                        4'd1:    begin sda_next = 1'b0; delay_next = hold1; end
                        4'd2:    begin scl_next = 1'b1; delay_next = hold5; end
                        4'd3:    begin sda_next = 1'b1; delay_next = hold5; end
                        default: ph_ok = 1'b0;
                    endcase
                end
                CMD_SEND:
                begin
                    unique case (phase_next)
                        4'd0:    begin sda_next = shift_next[7]; delay_next = hold1; end
                        4'd1:    begin scl_next = 1'b1; delay_next = hold5; end
                        4'd2:    begin scl_next = 1'b0; delay_next = hold2; end
                        4'd3:    begin sda_next = 1'b1; delay_next = hold1; end
                        4'd4:    begin scl_next = 1'b1; delay_next = hold1; end
                        PH_WAIT: begin wait_next = 17'd0; delay_next = 11'd0; end
                        4'd6:    begin scl_next = 1'b0; delay_next = hold2; end
                        default: ph_ok = 1'b0;
                    endcase
                end
                CMD_RECV:
                begin
                    unique case (phase_next)
                        4'd0:
                        begin
                            sda_next   = 1'b1;
                            scl_next   = 1'b0;
                            delay_next = hold2;
                        end
                        4'd1:    begin scl_next = 1'b1; delay_next = hold5; end
                        4'd2:    begin scl_next = 1'b0; delay_next = hold2; end
                        default: ph_ok = 1'b0;
                    endcase
                end
                CMD_ACK:
                begin
                    unique case (phase_next)
                        4'd0:    begin sda_next = 1'b0; delay_next = hold2; end
                        4'd1:    begin scl_next = 1'b1; delay_next = hold5; end
                        4'd2:
                        begin
                            scl_next   = 1'b0;
                            sda_next   = 1'b1;
                            delay_next = hold2;
                        end
                        default: ph_ok = 1'b0;
                    endcase
                end
                CMD_NACK:
                begin
                    unique case (phase_next)
                        4'd0:    begin sda_next = 1'b1; delay_next = hold2; end
                        4'd1:    begin scl_next = 1'b1; delay_next = hold5; end
                        4'd2:    begin scl_next = 1'b0; delay_next = hold2; end
                        default: ph_ok = 1'b0;
                    endcase
                end
                default: ph_ok = 1'b0;
            endcase
            if (!ph_ok)
            begin
                cmd_next   = CMD_IDLE;
                phase_next = 4'd0;
                delay_next = 11'd0;
                done       = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ack_timeout_reg <= ACK_TIMEOUT_RST;
            tpu_reg         <= TICKS_PER_UNIT_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_ACK_TIMEOUT:    ack_timeout_reg <= cfg_data;
                CFG_TICKS_PER_UNIT: tpu_reg         <= cfg_data[7:0];
                default:            ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cmd_reg   <= CMD_IDLE;
            phase_reg <= 4'd0;
            bit_reg   <= 4'd0;
            shift_reg <= 8'd0;
            delay_reg <= 11'd0;
            wait_reg  <= 17'd0;
            scl_reg   <= 1'b1;
            sda_reg   <= 1'b1;
            ack_reg   <= 1'b0;
            rx_reg    <= 8'd0;
        end
        else if (pop)
        begin
            cmd_reg   <= cmd_next;
            phase_reg <= phase_next;
            bit_reg   <= bit_next;
            shift_reg <= shift_next;
            delay_reg <= delay_next;
            wait_reg  <= wait_next;
            scl_reg   <= scl_next;
            sda_reg   <= sda_next;
            ack_reg   <= ack_next;
            rx_reg    <= rx_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (pop)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            out_res_reg.scl_out      <= scl_next;
            out_res_reg.sda_out      <= sda_next;
            out_res_reg.busy_res     <= (cmd_next != CMD_IDLE);
            out_res_reg.done_res     <= done;
            out_res_reg.ack_received <= ack_next;
            out_res_reg.rx_byte      <= rx_next;
        end
    end

endmodule
`default_nettype wire

### hdl/i2c_master_bit_engine.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// i2c_master_bit_engine
// I2C master bit engine: start, stop, send/receive byte, ACK and NACK driven
// by tick items, with ACK timeout and automatic stop.
// ----------------------------------------------------------------------------
// Every input transfer (tick, command or no-op) yields exactly one result
// transfer holding the bus levels and status after that item. The engine
// takes one item per clock while the output side is ready: the classifier
// feeds a two-entry queue, and the bit engine retires one queued item per
// cycle into a registered result stage. Items pass the queue, then the result
// register. Configuration writes are always accepted.
module i2c_master_bit_engine (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [15:0] s_tdata,   // tx_byte[7:0], sda_line[8], zero[15:9]
    input  wire logic [2:0]  s_tuser,   // mode[2:0]
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [15:0]      m_tdata,   // scl_out, sda_out, busy_res, done_res,
                                        // ack_received, rx_byte[12:5], zero[15:13]
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [0:0]  cfg_index,
    input  wire logic [15:0] cfg_data
);
    import i2cm_pkg::*;

    item_t     front_item;
    item_t     head_item;
    logic      head_valid;
    logic      pop;
    q_status_t q_status;
    result_t   res;

    assign s_tready  = !q_status.full;
    assign cfg_ready = 1'b1;

    i2cm_front u_front (
        .mode (s_tuser),
        .data (s_tdata),
        .item (front_item)
    );

    i2cm_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (s_tvalid),
        .push_item  (front_item),
        .pop        (pop),
        .head_valid (head_valid),
        .head_item  (head_item),
        .status     (q_status)
    );

    i2cm_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (head_valid),
        .in_item   (head_item),
        .pop       (pop),
        .cfg_we    (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_res   (res)
    );

    assign m_tdata = {3'd0, res.rx_byte, res.ack_received, res.done_res,
                      res.busy_res, res.sda_out, res.scl_out};

    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tdata[3] |-> !m_tdata[2])
        else $error("done reported while still busy");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        q_status.count <= QCNT_W'(QUEUE_DEPTH))
        else $error("queue count overflow");

    a_out_drain: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tready && !pop |=> !m_tvalid)
        else $error("result repeated after transfer");

    a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        $past(q_status.count) == '0 && !$past(s_tvalid && s_tready) |-> !pop ||
        q_status.count != '0)
        else $error("engine consumed from empty queue");

endmodule
`default_nettype wire

### verif/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the I2C master bit engine. A bit-level model of the
// engine predicts the bus levels and status for every accepted input
// transfer; each output transfer is checked field by field in order. Runs
// directed sequences for each command, ignored items, ACK timeout, slow bus
// timing and one long output hold-off, then random command sequences under
// several idle/stall mixes.
// ----------------------------------------------------------------------------
module tb;
    import i2cm_pkg::*;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [15:0] s_tdata = '0;
    logic [2:0]  s_tuser = MODE_TICK;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [15:0] m_tdata;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [0:0]  cfg_index = CFG_ACK_TIMEOUT;
    logic [15:0] cfg_data = '0;

    i2c_master_bit_engine dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #2 clk = ~clk;

    // bus model state
    cmd_t        cur_cmd = CMD_IDLE;
    logic [3:0]  cur_phase = '0;
    logic [3:0]  bit_cnt = '0;
    logic [7:0]  shreg = '0;
    logic [7:0]  rx_hold = '0;
    logic [10:0] hold_ticks = '0;
    logic [16:0] ack_wait = '0;
    logic        scl_lvl = 1'b1;
    logic        sda_lvl = 1'b1;
    logic        acked = 1'b0;
    logic [15:0] timeout_cfg = ACK_TIMEOUT_RST;
    logic [7:0]  tpu_cfg = TICKS_PER_UNIT_RST;

    result_t snap_q[$];
    bit      failed = 1'b0;
    int      items_sent = 0;
    int      send_gap_pct = 0;
    int      recv_stall_pct = 0;
    int      hold_cnt = 0;

    function automatic void load_hold(input int units);
        int t;
        int prod;
        t = (tpu_cfg == 8'd0) ? 1 : int'(tpu_cfg);
        prod = units * t;
        hold_ticks = prod[10:0];
    endfunction

    function automatic bit apply_phase();
        bit ok;
        ok = 1'b1;
        case (cur_cmd)
            CMD_START:
                case (cur_phase)
                    4'd0: begin sda_lvl = 1'b1; load_hold(1); end
                    4'd1: begin scl_lvl = 1'b1; load_hold(5); end
                    4'd2: begin sda_lvl = 1'b0; load_hold(5); end
                    4'd3: begin scl_lvl = 1'b0; load_hold(2); end
                    default: ok = 1'b0;
                endcase
            CMD_STOP:
                case (cur_phase)
                    4'd0: begin scl_lvl = 1'b0; load_hold(2); end
                    4'd1: begin sda_lvl = 1'b0; load_hold(1); end
                    4'd2: begin scl_lvl = 1'b1; load_hold(5); end
                    4'd3: begin sda_lvl = 1'b1; load_hold(5); end
                    default: ok = 1'b0;
                endcase
            CMD_SEND:
                case (cur_phase)
                    4'd0: begin sda_lvl = shreg[7]; load_hold(1); end
                    4'd1: begin scl_lvl = 1'b1; load_hold(5); end
                    4'd2: begin scl_lvl = 1'b0; load_hold(2); end
                    4'd3: begin sda_lvl = 1'b1; load_hold(1); end
                    4'd4: begin scl_lvl = 1'b1; load_hold(1); end
                    PH_WAIT: begin ack_wait = '0; hold_ticks = '0; end
                    4'd6: begin scl_lvl = 1'b0; load_hold(2); end
                    default: ok = 1'b0;
                endcase
            CMD_RECV:
                case (cur_phase)
                    4'd0: begin sda_lvl = 1'b1; scl_lvl = 1'b0; load_hold(2); end
                    4'd1: begin scl_lvl = 1'b1; load_hold(5); end
                    4'd2: begin scl_lvl = 1'b0; load_hold(2); end
                    default: ok = 1'b0;
                endcase
            CMD_ACK:
                case (cur_phase)
                    4'd0: begin sda_lvl = 1'b0; load_hold(2); end
                    4'd1: begin scl_lvl = 1'b1; load_hold(5); end
                    4'd2: begin scl_lvl = 1'b0; sda_lvl = 1'b1; load_hold(2); end
                    default: ok = 1'b0;
                endcase
            CMD_NACK:
                case (cur_phase)
                    4'd0: begin sda_lvl = 1'b1; load_hold(2); end
                    4'd1: begin scl_lvl = 1'b1; load_hold(5); end
                    4'd2: begin scl_lvl = 1'b0; load_hold(2); end
                    default: ok = 1'b0;
                endcase
            default: ok = 1'b0;
        endcase
        return ok;
    endfunction

    // returns 1 when the sequence has run past its last phase
    function automatic logic enter_or_finish();
        if (apply_phase())
            return 1'b0;
        cur_cmd = CMD_IDLE;
        cur_phase = '0;
        hold_ticks = '0;
        return 1'b1;
    endfunction

    function automatic logic next_phase(input logic sda_in);
        if (cur_cmd == CMD_SEND && cur_phase == 4'd2)
        begin
            shreg = {shreg[6:0], 1'b0};
            bit_cnt = bit_cnt + 4'd1;
            cur_phase = (bit_cnt < BITS_PER_BYTE) ? 4'd0 : 4'd3;
        end
        else if (cur_cmd == CMD_RECV && cur_phase == 4'd1)
        begin
            shreg = {shreg[6:0], sda_in};
            bit_cnt = bit_cnt + 4'd1;
            if (bit_cnt < BITS_PER_BYTE)
            begin
                cur_phase = 4'd0;
            end
            else
            begin
                rx_hold = shreg;
                cur_phase = 4'd2;
            end
        end
        else
        begin
            cur_phase = cur_phase + 4'd1;
        end
        return enter_or_finish();
    endfunction

    function automatic result_t bus_step(input logic [2:0] mode, input logic [7:0] tx,
                                         input logic sda_in);
        result_t r;
        logic    fin;
        fin = 1'b0;
        if (mode == MODE_TICK)
        begin
            if (cur_cmd != CMD_IDLE)
            begin
                if (cur_cmd == CMD_SEND && cur_phase == PH_WAIT)
                begin
                    if (!sda_in)
                    begin
                        acked = 1'b1;
                        cur_phase = 4'd6;
                        fin = enter_or_finish();
                    end
                    else if (ack_wait > {1'b0, timeout_cfg})
                    begin
                        acked = 1'b0;
                        cur_cmd = CMD_STOP;
                        cur_phase = '0;
                        fin = enter_or_finish();
                    end
                    else
                    begin
                        ack_wait = ack_wait + 17'd1;
                    end
                end
                else
                begin
                    if (hold_ticks > 0)
                        hold_ticks = hold_ticks - 11'd1;
                    if (hold_ticks == 0)
                        fin = next_phase(sda_in);
                end
            end
        end
        else if (mode != MODE_INVALID && cur_cmd == CMD_IDLE)
        begin
            cur_cmd = cmd_t'(mode);
            cur_phase = '0;
            bit_cnt = '0;
            ack_wait = '0;
            shreg = (cmd_t'(mode) == CMD_SEND) ? tx : 8'd0;
            fin = enter_or_finish();
        end
        r.scl_out = scl_lvl;
        r.sda_out = sda_lvl;
        r.busy_res = (cur_cmd != CMD_IDLE);
        r.done_res = fin;
        r.ack_received = acked;
        r.rx_byte = rx_hold;
        return r;
    endfunction

    task automatic cmp_field(input string name, input logic [7:0] exp_v,
                             input logic [7:0] act_v);
        if (exp_v !== act_v)
        begin
            $display("%0t: %s mismatch, expected %h actual %h", $time, name, exp_v, act_v);
            failed = 1'b1;
        end
    endtask

    // output side: check each transfer
    always @(posedge clk)
    begin
        result_t e;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (snap_q.size() == 0)
            begin
                $display("%0t: unexpected result, expected none actual %h", $time, m_tdata);
                failed = 1'b1;
            end
            else
            begin
                e = snap_q.pop_front();
                cmp_field("scl_out", 8'(e.scl_out), 8'(m_tdata[0]));
                cmp_field("sda_out", 8'(e.sda_out), 8'(m_tdata[1]));
                cmp_field("busy_res", 8'(e.busy_res), 8'(m_tdata[2]));
                cmp_field("done_res", 8'(e.done_res), 8'(m_tdata[3]));
                cmp_field("ack_received", 8'(e.ack_received), 8'(m_tdata[4]));
                cmp_field("rx_byte", e.rx_byte, m_tdata[12:5]);
            end
        end
    end

    // output ready: long hold-off when requested, random stalls otherwise
    always @(posedge clk)
    begin
        if (hold_cnt > 0)
        begin
            hold_cnt = hold_cnt - 1;
            m_tready <= 1'b0;
        end
        else
        begin
            m_tready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    task automatic send_item(input logic [2:0] mode, input logic [7:0] tx, input logic sda);
        while ($urandom_range(99) < send_gap_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser <= mode;
        s_tdata <= {7'd0, sda, tx};
        do @(posedge clk); while (!s_tready);
        snap_q.push_back(bus_step(mode, tx, sda));
        items_sent++;
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        while (snap_q.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_cfg(input logic [0:0] idx, input logic [15:0] val);
        drain();
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        if (idx == CFG_ACK_TIMEOUT)
            timeout_cfg = val;
        else
            tpu_cfg = val[7:0];
    endtask

    function automatic logic pick_sda(input int low_pct);
        return ($urandom_range(99) < low_pct) ? 1'b0 : 1'b1;
    endfunction

    // one command, then ticks until the model goes idle; noise = ignored items
    task automatic run_seq(input logic [2:0] mode, input logic [7:0] tx, input int low_pct,
                           input int noise_pct);
        logic [2:0] junk;
        send_item(mode, tx, pick_sda(low_pct));
        while (cur_cmd != CMD_IDLE)
        begin
            if ($urandom_range(99) < noise_pct)
            begin
                junk = 3'($urandom_range(1, 7));
                send_item(junk, 8'($urandom), pick_sda(50));
            end
            else
            begin
                send_item(MODE_TICK, 8'($urandom), pick_sda(low_pct));
            end
        end
    endtask

    function automatic logic [2:0] pick_cmd();
        int p;
        p = $urandom_range(99);
        if (p < 15) return CMD_START;
        if (p < 30) return CMD_STOP;
        if (p < 60) return CMD_SEND;
        if (p < 85) return CMD_RECV;
        if (p < 92) return CMD_ACK;
        return CMD_NACK;
    endfunction

    task automatic test_idle_items();
        send_item(MODE_TICK, 8'h00, 1'b0);
        send_item(MODE_TICK, 8'hFF, 1'b1);
        send_item(MODE_INVALID, 8'hA5, 1'b1);
        send_item(MODE_INVALID, 8'h5A, 1'b0);
    endtask

    task automatic test_commands();
        run_seq(CMD_START, 8'h00, 50, 0);
        run_seq(CMD_SEND, 8'hFF, 100, 0);
        run_seq(CMD_RECV, 8'h3C, 50, 0);
        run_seq(CMD_ACK, 8'h00, 50, 0);
        run_seq(CMD_NACK, 8'h00, 50, 0);
        run_seq(CMD_STOP, 8'h00, 50, 0);
    endtask

    task automatic test_busy_commands();
        run_seq(CMD_RECV, 8'h00, 50, 40);
    endtask

    task automatic test_ack_timeout();
        write_cfg(CFG_ACK_TIMEOUT, 16'd0);
        run_seq(CMD_SEND, 8'hC3, 0, 0);
    endtask

    task automatic test_slow_units();
        write_cfg(CFG_TICKS_PER_UNIT, 16'd0);
        run_seq(CMD_NACK, 8'h00, 50, 5);
        write_cfg(CFG_TICKS_PER_UNIT, 16'd3);
        run_seq(CMD_START, 8'h00, 50, 5);
    endtask

    task automatic test_backpressure();
        send_gap_pct = 0;
        recv_stall_pct = 0;
        write_cfg(CFG_TICKS_PER_UNIT, 16'd1);
        hold_cnt = 120;
        run_seq(CMD_RECV, 8'h00, 50, 0);
    endtask

    task automatic test_random(input int gap_pct, input int stall_pct, input int n_items,
                               input logic [15:0] tmo, input logic [7:0] tpu);
        int start_cnt;
        int low_pct;
        int p;
        send_gap_pct = gap_pct;
        recv_stall_pct = stall_pct;
        write_cfg(CFG_ACK_TIMEOUT, tmo);
        write_cfg(CFG_TICKS_PER_UNIT, {8'd0, tpu});
        start_cnt = items_sent;
        while (items_sent - start_cnt < n_items)
        begin
            p = $urandom_range(99);
            if (p < 4)
            begin
                send_item(MODE_TICK, 8'($urandom), pick_sda(50));
            end
            else if (p < 7)
            begin
                send_item(MODE_INVALID, 8'($urandom), pick_sda(50));
            end
            else
            begin
                low_pct = $urandom_range(0, 60);
                if (timeout_cfg > 16'd64 && low_pct < 5)
                    low_pct = 5;
                run_seq(pick_cmd(), 8'($urandom), low_pct, 10);
            end
        end
    endtask

    initial
    begin
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_idle_items();
        test_commands();
        test_busy_commands();
        test_ack_timeout();
        test_slow_units();
        test_backpressure();
        test_random(0, 0, 90, 16'($urandom_range(0, 8)), 8'd1);
        test_random(51, 0, 90, 16'($urandom_range(9, 300)), 8'($urandom_range(1, 3)));
        test_random(0, 51, 90, 16'hFFFF, 8'd1);
        test_random(14, 14, 90, 16'($urandom_range(0, 4)), 8'($urandom_range(2, 4)));
        drain();
        repeat (16) @(posedge clk);
        if (!failed)
            $display("i2c_master_bit_engine test passed");
        else
            $display("i2c_master_bit_engine test failed");
        $finish;
    end

    initial
    begin
        #3_000_000;
        $display("i2c_master_bit_engine test failed");
        $finish;
    end

endmodule

### filelist.f
hdl/i2cm_pkg.sv
hdl/i2cm_front.sv
hdl/i2cm_queue.sv
hdl/i2cm_back.sv
hdl/i2c_master_bit_engine.sv
verif/tb.sv
